// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the anti-poisoning sequencer core RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dasq_pkg.sv =====
// Shared types and constants of the display anti-poisoning sequencer.
// No dependencies; used by dasq_core and the top level.
`default_nettype none

package dasq_pkg;

	localparam int NUM_DIGITS = 4;

	typedef logic [3:0]                  digit_t;
	typedef digit_t [NUM_DIGITS-1:0]     digits_t;
	typedef logic [15:0]                 interval_t;
	typedef logic [3:0]                  passes_t;
	typedef logic                        cfg_idx_t;

	localparam digit_t    DIGIT_MAX  = 4'd9;
	localparam interval_t TICK_MAX   = 16'hFFFF;

	// Four steps per half second at a 1 kHz tick.
	localparam interval_t STEP_INTERVAL_RST = 16'(1000 / 2 / 4);
	localparam passes_t   SWEEP_PASSES_RST  = 4'd3;

	// Configuration register indexes
	localparam cfg_idx_t CFG_IDX_STEP_INTERVAL = 1'b0;
	localparam cfg_idx_t CFG_IDX_SWEEP_PASSES  = 1'b1;

	typedef struct packed {
		logic    repeat_mode;
		digit_t  sweep_value;
		digits_t shown;
		logic    done_res;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/display_antipoison_sequencer_unit.sv =====
// Top level of the display anti-poisoning sequencer: handshakes, configuration
// registers, input and result registers. Depends on dasq_pkg and dasq_core.
`default_nettype none

// Each input beat is one time tick carrying the four target clock digits, and
// each tick yields exactly one result beat. The block counts ticks and takes one
// animation step whenever the count reaches step_interval. It first sweeps one
// digit, shown on every tube, up from 0 to 9 and back down, holding each end for
// one extra step; every return to 0 completes a pass. After sweep_passes passes
// it shows a four-digit number starting at 0000 that moves towards the target,
// one unit on the highest-indexed differing digit per step, and raises done_res on a
// step that finds nothing left to move. Target digits above 9 are taken as 9.
// One tick is taken per clock cycle while out_ready is high; each tick passes
// through the input register and then the result register, with combinational
// step logic between them. The result register decouples the two sides, so a
// new tick is taken while a finished result still waits, and stalls only
// propagate back once both registers are full. Configuration writes are always
// accepted and should be made only while no tick is in flight.
module display_antipoison_sequencer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [3:0] target_d0,
	input  wire logic [3:0] target_d1,
	input  wire logic [3:0] target_d2,
	input  wire logic [3:0] target_d3,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            repeat_mode,
	output logic [3:0]      sweep_value,
	output logic [3:0]      shown_d0,
	output logic [3:0]      shown_d1,
	output logic [3:0]      shown_d2,
	output logic [3:0]      shown_d3,
	output logic            done_res,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [15:0] cfg_data
);

	dasq_pkg::interval_t step_interval_q;
	dasq_pkg::passes_t   sweep_passes_q;
	dasq_pkg::digits_t   tgt_in, tgt_s1;
	dasq_pkg::result_t   res_next, res_s2;
	logic                valid_s1, valid_s2;
	logic                adv, load;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_interval_q <= dasq_pkg::STEP_INTERVAL_RST;
			sweep_passes_q  <= dasq_pkg::SWEEP_PASSES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dasq_pkg::CFG_IDX_STEP_INTERVAL: step_interval_q <= cfg_data;
				dasq_pkg::CFG_IDX_SWEEP_PASSES:  sweep_passes_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// The result register moves on when it is empty or its beat is being taken;
	// the input register can then refill in the same cycle.
	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign load     = valid_s1 && adv;

	// Out-of-range target digits are clamped before they reach the step logic.
	always_comb begin
		tgt_in[0] = (target_d0 > dasq_pkg::DIGIT_MAX) ? dasq_pkg::DIGIT_MAX : target_d0;
		tgt_in[1] = (target_d1 > dasq_pkg::DIGIT_MAX) ? dasq_pkg::DIGIT_MAX : target_d1;
		tgt_in[2] = (target_d2 > dasq_pkg::DIGIT_MAX) ? dasq_pkg::DIGIT_MAX : target_d2;
		tgt_in[3] = (target_d3 > dasq_pkg::DIGIT_MAX) ? dasq_pkg::DIGIT_MAX : target_d3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tgt_s1 <= tgt_in;
		end
		if (load) begin
			res_s2 <= res_next;
		end
	end

	// Tick counter, sweep and approach state live in the core; it advances only
	// when the beat in the input register moves into the result register.
	dasq_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.tgt           (tgt_s1),
		.step_interval (step_interval_q),
		.sweep_passes  (sweep_passes_q),
		.res           (res_next)
	);

	assign out_valid   = valid_s2;
	assign repeat_mode = res_s2.repeat_mode;
	assign sweep_value = res_s2.sweep_value;
	assign shown_d0    = res_s2.shown[0];
	assign shown_d1    = res_s2.shown[1];
	assign shown_d2    = res_s2.shown[2];
	assign shown_d3    = res_s2.shown[3];
	assign done_res    = res_s2.done_res;

endmodule

`default_nettype wire

// ===== rtl/core/dasq_core.sv =====
// Animation state and single-step logic of the anti-poisoning sequencer.
// Depends on dasq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dasq_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire dasq_pkg::digits_t  tgt,
	input  wire dasq_pkg::interval_t step_interval,
	input  wire dasq_pkg::passes_t  sweep_passes,
	output dasq_pkg::result_t       res
);

	dasq_pkg::interval_t tick_q, tick_inc, tick_d;
	dasq_pkg::digit_t    sweep_digit_q, sweep_digit_d;
	logic                sweep_down_q, sweep_down_d;
	dasq_pkg::passes_t   pass_q, pass_d;
	dasq_pkg::digits_t   appr_q, appr_d;
	logic                step, sweeping, found, done;

	always_comb begin
		tick_inc      = (tick_q == dasq_pkg::TICK_MAX) ? tick_q : tick_q + 16'd1;
		step          = (tick_inc >= step_interval);
		sweeping      = (pass_q < sweep_passes);
		tick_d        = step ? '0 : tick_inc;
		sweep_digit_d = sweep_digit_q;
		sweep_down_d  = sweep_down_q;
		pass_d        = pass_q;
		appr_d        = appr_q;
		found         = 1'b0;
		done          = 1'b0;

		if (step && sweeping) begin
			if (!sweep_down_q) begin
				if (sweep_digit_q >= dasq_pkg::DIGIT_MAX) begin
					sweep_digit_d = dasq_pkg::DIGIT_MAX;
					sweep_down_d  = 1'b1;
				end else begin
					sweep_digit_d = sweep_digit_q + 4'd1;
				end
			end else begin
				// Bottom is held one extra step; that step closes the pass.
				if (sweep_digit_q == '0) begin
					sweep_down_d = 1'b0;
					pass_d       = pass_q + 4'd1;
				end else begin
					sweep_digit_d = sweep_digit_q - 4'd1;
				end
			end
		end

		if (step && !sweeping) begin
			// Highest-indexed differing digit wins.
			for (int i = dasq_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
				if (!found && appr_q[i] != tgt[i]) begin
					found = 1'b1;
					if (appr_q[i] < tgt[i]) begin
						appr_d[i] = appr_q[i] + 4'd1;
					end else begin
						appr_d[i] = appr_q[i] - 4'd1;
					end
				end
			end
			done = !found;
		end

		res.repeat_mode = sweeping;
		res.sweep_value = sweep_digit_d;
		res.shown       = appr_d;
		res.done_res    = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			sweep_digit_q <= '0;
			sweep_down_q  <= 1'b0;
			pass_q        <= '0;
			appr_q        <= '0;
		end else if (load) begin
			tick_q        <= tick_d;
			sweep_digit_q <= sweep_digit_d;
			sweep_down_q  <= sweep_down_d;
			pass_q        <= pass_d;
			appr_q        <= appr_d;
		end
	end

	`ASSERT_ALWAYS(a_sweep_digit_range, sweep_digit_q <= dasq_pkg::DIGIT_MAX, "sweep digit above nine")
	`ASSERT_ALWAYS(a_approach_range, (appr_q[0] <= dasq_pkg::DIGIT_MAX) && (appr_q[1] <= dasq_pkg::DIGIT_MAX) && (appr_q[2] <= dasq_pkg::DIGIT_MAX) && (appr_q[3] <= dasq_pkg::DIGIT_MAX), "approach digit above nine")
	`ASSERT_IMPLIES(a_pass_on_wrap, load && (pass_d != pass_q), sweep_down_q && (sweep_digit_q == '0) && sweeping, "pass count moved outside a sweep wrap")
	`ASSERT_IMPLIES(a_done_in_approach, res.done_res, !res.repeat_mode && step, "done raised outside an approach step")

endmodule

`default_nettype wire
